// ===== rtl/gpeo_pkg.sv =====
package gpeo_pkg;

    localparam int PHASE_BITS    = 24;
    localparam int SINE_DEPTH    = 1024;
    localparam int SINE_IDX_BITS = $clog2(SINE_DEPTH);
    localparam int SAMPLE_BITS   = 24;
    localparam int ENV_SHIFT     = 47 - SAMPLE_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_ENVELOPE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LEN     = 3'd5;

    localparam logic [1:0] WAVE_FLAT   = 2'd0;
    localparam logic [1:0] WAVE_SINE   = 2'd1;
    localparam logic [1:0] WAVE_SAW    = 2'd2;
    localparam logic [1:0] WAVE_SQUARE = 2'd3;

    typedef struct packed {
        logic                          voice_on;
        logic                          snap;
        logic [23:0]                   sample_time;
        logic [PHASE_BITS-1:0]         step_target;
        logic [15:0]                   amp_target;
        logic [16:0]                   pan_target;
        logic signed [SAMPLE_BITS-1:0] bus_left_in;
        logic signed [SAMPLE_BITS-1:0] bus_right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] bus_left_out;
        logic signed [SAMPLE_BITS-1:0] bus_right_out;
        logic                          clipped;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic env;
        logic mul_step;
        logic write;
    } t_dp_cmd;

    typedef struct packed {
        logic voice_on;
        logic div_done;
        logic mul_done;
    } t_dp_sts;

    typedef logic signed [15:0] t_sine_tab [SINE_DEPTH];

    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        x2 = (x * x) >> 30;
        t  = 64'(1) << 30;
        t  = (64'(1) << 30) - x2 / 110;
        t  = (64'(1) << 30) - ((x2 * t) >> 30) / 72;
        t  = (64'(1) << 30) - ((x2 * t) >> 30) / 42;
        t  = (64'(1) << 30) - ((x2 * t) >> 30) / 20;
        t  = (64'(1) << 30) - ((x2 * t) >> 30) / 6;
        return (x * t) >> 30;
    endfunction

    function automatic t_sine_tab build_sine();
        t_sine_tab   tab;
        logic [63:0] u;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] v;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            u = (64'(k) << 32) / SINE_DEPTH;
            q = (u >> 30) & 64'd3;
            r = u & ((64'(1) << 30) - 64'd1);
            if (q[0]) r = (64'(1) << 30) - r;
            s = sin_q30((r * 64'd1686629713) >> 30);
            v = (s + (64'(1) << 14)) >> 15;
            if (v > 64'd32767) v = 64'd32767;
            tab[k] = q[1] ? -$signed(16'(v)) : $signed(16'(v));
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

endpackage

// ===== rtl/gpeo_ctrl.sv =====
module gpeo_ctrl
    import gpeo_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_DIV   = 6'b000100,
        S_ENV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_WRITE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = i_sts.voice_on;
                n_state    = i_sts.voice_on ? S_DIV : S_WRITE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) n_state = S_ENV;
            end
            S_ENV: begin
                o_cmd.env = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!r_valid || i_ready) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.write) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== rtl/gpeo_datapath.sv =====
module gpeo_datapath
    import gpeo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output t_out_item             o_out
);

    localparam int DIV_STEPS = 16;
    localparam int MUL_STEPS = 6;
    localparam int PROD_W    = 51;
    localparam int CONTRIB_W = PROD_W - ENV_SHIFT;
    localparam int SUM_W     = CONTRIB_W + 2;

    localparam logic [2:0] MS_AMP   = 3'd0;
    localparam logic [2:0] MS_GAIN  = 3'd1;
    localparam logic [2:0] MS_LEFT  = 3'd2;
    localparam logic [2:0] MS_RIGHT = 3'd3;
    localparam logic [2:0] MS_ENVL  = 3'd4;
    localparam logic [2:0] MS_ENVR  = 3'd5;

    localparam logic [1:0] ET_ONE  = 2'd0;
    localparam logic [1:0] ET_ZERO = 2'd1;
    localparam logic [1:0] ET_DIV  = 2'd2;

    localparam logic [16:0] ENV_ONE  = 17'd65536;
    localparam logic [16:0] PAN_STEP = 17'd7;
    localparam logic [16:0] ENV_STEP = 17'd66;

    function automatic logic [24:0] glide(input logic [24:0] now, input logic [24:0] tgt);
        if (tgt >= now) return now + ((tgt - now) >> 10);
        return now - ((now - tgt + 25'd1023) >> 10);
    endfunction

    function automatic logic [16:0] slew(input logic [16:0] now, input logic [16:0] tgt,
                                         input logic [16:0] step);
        if (tgt >= now) return (tgt - now < step) ? now : now + step;
        return (now - tgt < step) ? now : now - step;
    endfunction

    function automatic logic [SAMPLE_BITS:0] saturate(input logic signed [SAMPLE_BITS-1:0] bus,
                                                      input logic [CONTRIB_W-1:0] mag,
                                                      input logic neg);
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        sum = SUM_W'(bus);
        hi  = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
        lo  = -hi - SUM_W'(1);
        if (neg) sum = sum - $signed(SUM_W'(mag));
        else     sum = sum + $signed(SUM_W'(mag));
        if (sum > hi) return {1'b1, hi[SAMPLE_BITS-1:0]};
        if (sum < lo) return {1'b1, lo[SAMPLE_BITS-1:0]};
        return {1'b0, sum[SAMPLE_BITS-1:0]};
    endfunction

    logic [1:0]  r_waveform;
    logic [15:0] r_gain;
    logic        r_use_env;
    logic [23:0] r_attack_len, r_release_start, r_total_len;

    t_in_item              r_in;
    logic [PHASE_BITS-1:0] r_acc, r_step;
    logic [16:0]           r_amp, r_pan, r_env;
    logic [1:0]            r_et_mode;
    logic [24:0]           r_rem;
    logic [23:0]           r_div_d;
    logic [15:0]           r_q;
    logic [3:0]            r_cnt;
    logic signed [15:0]    r_sine;
    logic [14:0]           r_mag;
    logic                  r_neg;
    logic [31:0]           r_p0;
    logic [32:0]           r_m;
    logic [33:0]           r_l1, r_r1;
    logic [CONTRIB_W-1:0]  r_vl, r_vr;
    t_out_item             r_out;

    logic [16:0]           n_ptgt, n_pan;
    logic [PHASE_BITS-1:0] n_step;
    logic [23:0]           n_div_a, n_div_d;
    logic [1:0]            n_et_mode;
    logic [24:0]           n_shift;
    logic [16:0]           n_etgt;
    logic signed [16:0]    n_wave;
    logic [33:0]           n_mul_a;
    logic [16:0]           n_mul_b;
    logic [PROD_W-1:0]     n_prod;
    logic [PROD_W-1:0]     n_rnd15, n_rnd16, n_rnde;
    logic [SAMPLE_BITS:0]  n_sat_l, n_sat_r;

    always_comb begin
        n_ptgt = (r_in.pan_target > ENV_ONE) ? ENV_ONE : r_in.pan_target;
        n_pan  = slew(r_in.snap ? n_ptgt : r_pan, n_ptgt, PAN_STEP);
        n_step = PHASE_BITS'(glide(25'(r_in.snap ? r_in.step_target : r_step),
                                   25'(r_in.step_target)));
        n_div_a   = r_in.sample_time;
        n_div_d   = r_attack_len;
        n_et_mode = ET_ONE;
        if (r_use_env) begin
            if (r_in.sample_time < r_attack_len) begin
                n_et_mode = ET_DIV;
            end else if (r_in.sample_time > r_release_start) begin
                n_div_a = r_total_len - r_in.sample_time;
                n_div_d = r_total_len - r_release_start;
                if (r_total_len <= r_release_start || r_in.sample_time >= r_total_len)
                    n_et_mode = ET_ZERO;
                else
                    n_et_mode = ET_DIV;
            end
        end
    end

    assign n_shift = {r_rem[23:0], 1'b0};

    always_comb begin
        case (r_et_mode)
            ET_ONE:  n_etgt = ENV_ONE;
            ET_ZERO: n_etgt = '0;
            default: n_etgt = {1'b0, r_q};
        endcase
    end

    always_comb begin
        case (r_waveform)
            WAVE_SINE: n_wave = 17'(r_sine);
            WAVE_SAW: begin
                n_wave = 17'sd32768 - $signed({1'b0, r_acc[PHASE_BITS-1 -: 16]});
                if (n_wave > 17'sd32767) n_wave = 17'sd32767;
            end
            WAVE_SQUARE: n_wave = r_acc[PHASE_BITS-1] ? -17'sd32767 : 17'sd32767;
            default: n_wave = '0;
        endcase
    end

    always_comb begin
        case (r_cnt[2:0])
            MS_AMP:   begin n_mul_a = 34'(r_mag); n_mul_b = r_amp; end
            MS_GAIN:  begin n_mul_a = 34'(r_p0);  n_mul_b = 17'(r_gain); end
            MS_LEFT:  begin n_mul_a = 34'(r_m);   n_mul_b = ENV_ONE - r_pan; end
            MS_RIGHT: begin n_mul_a = 34'(r_m);   n_mul_b = r_pan; end
            MS_ENVL:  begin n_mul_a = r_l1;       n_mul_b = r_env; end
            default:  begin n_mul_a = r_r1;       n_mul_b = r_env; end
        endcase
        n_prod  = PROD_W'(n_mul_a) * PROD_W'(n_mul_b);
        n_rnd15 = n_prod + (PROD_W'(1) << 14);
        n_rnd16 = n_prod + (PROD_W'(1) << 15);
        n_rnde  = n_prod + (PROD_W'(1) << (ENV_SHIFT - 1));
    end

    assign n_sat_l = saturate(r_in.bus_left_in, r_vl, r_neg);
    assign n_sat_r = saturate(r_in.bus_right_in, r_vr, r_neg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform      <= WAVE_SINE;
            r_gain          <= 16'd16384;
            r_use_env       <= 1'b1;
            r_attack_len    <= 24'd4410;
            r_release_start <= 24'd39690;
            r_total_len     <= 24'd44100;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WAVEFORM:      r_waveform      <= i_cfg_data[1:0];
                CFG_GAIN:          r_gain          <= i_cfg_data[15:0];
                CFG_USE_ENVELOPE:  r_use_env       <= i_cfg_data[0];
                CFG_ATTACK_LEN:    r_attack_len    <= i_cfg_data[23:0];
                CFG_RELEASE_START: r_release_start <= i_cfg_data[23:0];
                CFG_TOTAL_LEN:     r_total_len     <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_step <= '0;
            r_amp  <= '0;
            r_pan  <= 17'd32768;
            r_env  <= '0;
        end else begin
            if (i_cmd.prep) begin
                r_pan  <= n_pan;
                r_step <= n_step;
                r_acc  <= r_acc + n_step;
                r_amp  <= 17'(glide(25'(r_amp), 25'(r_in.amp_target)));
            end
            if (i_cmd.env) r_env <= slew(r_env, n_etgt, ENV_STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine <= SINE_TAB[r_acc[PHASE_BITS-1 -: SINE_IDX_BITS]];
        if (i_cmd.load) r_in <= i_in;
        if (i_cmd.prep) begin
            r_rem     <= 25'(n_div_a);
            r_div_d   <= n_div_d;
            r_q       <= '0;
            r_et_mode <= n_et_mode;
            r_cnt     <= '0;
        end
        if (i_cmd.div_step) begin
            if (n_shift >= {1'b0, r_div_d}) begin
                r_rem <= n_shift - {1'b0, r_div_d};
                r_q   <= {r_q[14:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_q   <= {r_q[14:0], 1'b0};
            end
            r_cnt <= r_cnt + 4'd1;
        end
        if (i_cmd.env) begin
            r_neg <= n_wave[16];
            r_mag <= n_wave[16] ? 15'(-n_wave) : n_wave[14:0];
            r_cnt <= '0;
        end
        if (i_cmd.mul_step) begin
            case (r_cnt[2:0])
                MS_AMP:   r_p0 <= n_prod[31:0];
                MS_GAIN:  r_m  <= n_rnd15[47:15];
                MS_LEFT:  r_l1 <= n_rnd16[49:16];
                MS_RIGHT: r_r1 <= n_rnd16[49:16];
                MS_ENVL:  r_vl <= n_rnde[PROD_W-1:ENV_SHIFT];
                default:  r_vr <= n_rnde[PROD_W-1:ENV_SHIFT];
            endcase
            r_cnt <= r_cnt + 4'd1;
        end
        if (i_cmd.write) begin
            if (r_in.voice_on) begin
                r_out.bus_left_out  <= n_sat_l[SAMPLE_BITS-1:0];
                r_out.bus_right_out <= n_sat_r[SAMPLE_BITS-1:0];
                r_out.clipped       <= n_sat_l[SAMPLE_BITS] | n_sat_r[SAMPLE_BITS];
            end else begin
                r_out.bus_left_out  <= r_in.bus_left_in;
                r_out.bus_right_out <= r_in.bus_right_in;
                r_out.clipped       <= 1'b0;
            end
        end
    end

    assign o_sts.voice_on = r_in.voice_on;
    assign o_sts.div_done = (r_cnt == 4'(DIV_STEPS - 1));
    assign o_sts.mul_done = (r_cnt[2:0] == 3'(MUL_STEPS - 1));
    assign o_out          = r_out;

endmodule

// ===== rtl/glide_pan_envelope_oscillator_voice_core.sv =====
// Stereo oscillator voice: each input transaction produces one output transaction holding
// the two bus values with this voice added and saturated. A transaction with the voice on
// runs through a setup step, the bit-serial envelope divider, an envelope/wave step, the
// passes through the shared 34x17 multiplier and an output step; with the voice off it goes
// from setup straight to output. The next input is taken as soon as the result is in the
// output register. Configuration writes land in registers and must come while idle.
module glide_pan_envelope_oscillator_voice_core
    import gpeo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_item              i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    gpeo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gpeo_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while a transaction is in progress");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out)))
        else $error("pending result dropped or changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule

// ===== tb/tb_glide_pan_envelope_oscillator_voice_core.sv =====
module tb_glide_pan_envelope_oscillator_voice_core;
    import gpeo_pkg::*;

    localparam longint unsigned Q30 = 64'd1 << 30;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    t_in_item              i_in;
    logic                  o_valid;
    logic                  i_ready;
    t_out_item             o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    glide_pan_envelope_oscillator_voice_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // voice model state and register copies
    int              sine_lut [SINE_DEPTH];
    longint unsigned wave_sel, gain_q14, env_enable, attack_samples, release_at, stroke_end;
    longint unsigned acc_phase, cur_step, cur_amp, cur_pan, cur_env;

    t_out_item sample_queue [$];
    int        mismatch_count = 0;
    int        hold_cycles = 0;
    bit        hold_req = 1'b0;
    bit        hold_seen = 1'b0;
    bit        stall_enable;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned quarter_sine(longint unsigned a);
        longint unsigned a2;
        longint unsigned t;
        a2 = (a * a) >> 30;
        t  = Q30 - a2 / 110;
        t  = Q30 - ((a2 * t) >> 30) / 72;
        t  = Q30 - ((a2 * t) >> 30) / 42;
        t  = Q30 - ((a2 * t) >> 30) / 20;
        t  = Q30 - ((a2 * t) >> 30) / 6;
        return (a * t) >> 30;
    endfunction

    function automatic void fill_sine_lut();
        longint unsigned u;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned v;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            u    = (longint'(k) << 32) / SINE_DEPTH;
            quad = (u >> 30) & 3;
            r    = u & (Q30 - 1);
            if (quad[0]) r = Q30 - r;
            v = (quarter_sine((r * 64'd1686629713) >> 30) + (64'd1 << 14)) >> 15;
            if (v > 32767) v = 32767;
            sine_lut[k] = quad[1] ? -int'(v) : int'(v);
        end
    endfunction

    function automatic longint unsigned glide_to(longint unsigned now, longint unsigned tgt);
        if (tgt >= now) return now + ((tgt - now) >> 10);
        return now - ((now - tgt + 1023) >> 10);
    endfunction

    function automatic longint unsigned slew_to(longint unsigned now, longint unsigned tgt,
                                                longint unsigned stp);
        if (tgt >= now) return (tgt - now < stp) ? now : now + stp;
        return (now - tgt < stp) ? now : now - stp;
    endfunction

    function automatic longint unsigned round_shift(longint unsigned x, int n);
        return (x + (64'd1 << (n - 1))) >> n;
    endfunction

    function automatic longint unsigned envelope_goal(longint unsigned t);
        if (env_enable == 0) return 65536;
        if (t < attack_samples) return (t * 65536) / attack_samples;
        if (t > release_at) begin
            if (stroke_end <= release_at || t >= stroke_end) return 0;
            return ((stroke_end - t) * 65536) / (stroke_end - release_at);
        end
        return 65536;
    endfunction

    function automatic longint saturate(longint v, ref bit clip);
        longint hi;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
        if (v > hi) begin
            clip = 1'b1;
            return hi;
        end
        if (v < -hi - 1) begin
            clip = 1'b1;
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic void reset_voice_model();
        wave_sel = 1; gain_q14 = 16384; env_enable = 1;
        attack_samples = 4410; release_at = 39690; stroke_end = 44100;
        acc_phase = 0; cur_step = 0; cur_amp = 0; cur_pan = 32768; cur_env = 0;
    endfunction

    function automatic t_out_item voice_sample(t_in_item x);
        t_out_item       r;
        longint unsigned ptgt;
        longint unsigned etgt;
        longint unsigned mag;
        longint unsigned m;
        longint          w;
        longint          vl;
        longint          vr;
        bit              clip;
        clip = 1'b0;
        if (!x.voice_on) begin
            r.bus_left_out  = x.bus_left_in;
            r.bus_right_out = x.bus_right_in;
            r.clipped       = 1'b0;
            return r;
        end
        ptgt = x.pan_target;
        if (ptgt > 65536) ptgt = 65536;
        if (x.snap) begin
            cur_step = x.step_target;
            cur_pan  = ptgt;
        end
        cur_pan   = slew_to(cur_pan, ptgt, 7);
        cur_step  = glide_to(cur_step, x.step_target);
        etgt      = envelope_goal(x.sample_time);
        acc_phase = (acc_phase + cur_step) & ((64'd1 << PHASE_BITS) - 1);
        cur_amp   = glide_to(cur_amp, x.amp_target);
        cur_env   = slew_to(cur_env, etgt, 66);
        case (wave_sel)
            WAVE_SINE: w = sine_lut[acc_phase >> (PHASE_BITS - SINE_IDX_BITS)];
            WAVE_SAW: begin
                w = 32768 - longint'(acc_phase >> (PHASE_BITS - 16));
                if (w > 32767) w = 32767;
            end
            WAVE_SQUARE: w = acc_phase[PHASE_BITS-1] ? -32767 : 32767;
            default: w = 0;
        endcase
        mag = (w < 0) ? -w : w;
        m   = round_shift(mag * cur_amp * gain_q14, 15);
        vl  = round_shift(round_shift(m * (65536 - cur_pan), 16) * cur_env, ENV_SHIFT);
        vr  = round_shift(round_shift(m * cur_pan, 16) * cur_env, ENV_SHIFT);
        if (w < 0) begin
            vl = -vl;
            vr = -vr;
        end
        r.bus_left_out  = SAMPLE_BITS'(saturate(longint'(x.bus_left_in) + vl, clip));
        r.bus_right_out = SAMPLE_BITS'(saturate(longint'(x.bus_right_in) + vr, clip));
        r.clipped       = clip;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_WAVEFORM:      wave_sel       = val & 3;
            CFG_GAIN:          gain_q14       = val & 16'hFFFF;
            CFG_USE_ENVELOPE:  env_enable     = val & 1;
            CFG_ATTACK_LEN:    attack_samples = val & 24'hFFFFFF;
            CFG_RELEASE_START: release_at     = val & 24'hFFFFFF;
            CFG_TOTAL_LEN:     stroke_end     = val & 24'hFFFFFF;
            default: ;
        endcase
    endtask

    // drive at the falling edge, hold until accepted, then maybe open a gap
    task automatic send_sample(input t_in_item x, input bit allow_gap);
        if (!i_valid) @(negedge i_clk);
        i_valid = 1'b1;
        i_in    = x;
        do @(posedge i_clk); while (!o_ready);
        sample_queue.push_back(voice_sample(x));
        @(negedge i_clk);
        if (allow_gap && $urandom_range(0, 7) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (sample_queue.size() == 0);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic t_in_item random_sample(longint unsigned t);
        t_in_item x;
        x.voice_on     = ($urandom_range(0, 9) != 0);
        x.snap         = ($urandom_range(0, 15) == 0);
        x.sample_time  = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'(t);
        x.step_target  = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 400000));
        x.amp_target   = 16'($urandom_range(0, 32768));
        x.pan_target   = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        case ($urandom_range(0, 5))
            0: begin
                x.bus_left_in  = 24'sh7FFFF0 + 24'($urandom_range(0, 15));
                x.bus_right_in = 24'sh800000 + 24'($urandom_range(0, 15));
            end
            1: begin
                x.bus_left_in  = 24'sh800000;
                x.bus_right_in = 24'sh7FFFFF;
            end
            default: begin
                x.bus_left_in  = 24'($urandom);
                x.bus_right_in = 24'($urandom);
            end
        endcase
        return x;
    endfunction

    task automatic test_directed();
        t_in_item x;
        x = '0;
        x.bus_left_in = 24'sh7FFFFF; x.bus_right_in = 24'sh800000;
        send_sample(x, 1'b0);
        x = '1;
        x.voice_on = 1'b0;
        send_sample(x, 1'b0);
        drain();
        write_reg(CFG_USE_ENVELOPE, 0);
        write_reg(CFG_GAIN, 65535);
        for (int k = 0; k < 4; k++) begin
            write_reg(CFG_WAVEFORM, k);
            for (int j = 0; j < 4; j++) begin
                x = '0;
                x.voice_on     = 1'b1;
                x.snap         = (j == 0);
                x.sample_time  = 24'(j * 5000);
                x.step_target  = (j == 3) ? 24'hFFFFFF : 24'h200000;
                x.amp_target   = 16'd32768;
                x.pan_target   = (j == 1) ? 17'h1FFFF : 17'(j * 30000);
                x.bus_left_in  = (j == 2) ? 24'sh7FFFFF : 24'sh000000;
                x.bus_right_in = (j == 2) ? 24'sh800000 : 24'sh000000;
                send_sample(x, 1'b0);
            end
            drain();
        end
    endtask

    task automatic test_setting(input longint unsigned wave, input longint unsigned gain,
                                input longint unsigned use_env, input longint unsigned atk,
                                input longint unsigned rel, input longint unsigned tot,
                                input int n);
        longint unsigned t;
        write_reg(CFG_WAVEFORM, wave);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_USE_ENVELOPE, use_env);
        write_reg(CFG_ATTACK_LEN, atk);
        write_reg(CFG_RELEASE_START, rel);
        write_reg(CFG_TOTAL_LEN, tot);
        t = 0;
        for (int k = 0; k < n; k++) begin
            send_sample(random_sample(t), 1'b1);
            t = (t >= tot + 20) ? 0 : t + $urandom_range(1, 3);
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = ~hold_req;
        for (int k = 0; k < 12; k++) send_sample(random_sample(k), 1'b0);
        drain();
    endtask

    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_cycles <= 400;
            i_ready     <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (!stall_enable) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always begin
        stall_enable = 1'b0;
        repeat ($urandom_range(50, 400)) @(negedge i_clk);
        stall_enable = 1'b1;
        repeat ($urandom_range(50, 400)) @(negedge i_clk);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (sample_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected transaction %p", o_out);
            end else if (o_out !== sample_queue[0]) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch exp L %0d R %0d c %0b, got L %0d R %0d c %0b",
                             sample_queue[0].bus_left_out, sample_queue[0].bus_right_out,
                             sample_queue[0].clipped, o_out.bus_left_out,
                             o_out.bus_right_out, o_out.clipped);
                void'(sample_queue.pop_front());
            end else begin
                void'(sample_queue.pop_front());
            end
        end
    end

    initial begin
        #30000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_in = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        fill_sine_lut();
        reset_voice_model();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_setting(WAVE_SINE, 16384, 1, 4410, 39690, 44100, 200);
        test_setting(WAVE_SQUARE, 65535, 1, 60, 200, 300, 350);
        test_setting(WAVE_SAW, 40000, 1, 1, 0, 16777215, 250);
        test_setting(WAVE_SINE, 0, 1, 0, 100, 100, 150);
        test_setting(WAVE_SQUARE, 30000, 1, 16777215, 16777215, 1, 150);
        test_setting(WAVE_SINE, 65535, 0, 100, 150, 120, 350);
        test_setting(WAVE_FLAT, 65535, 1, 50, 80, 200, 100);
        test_backpressure();
        test_setting(WAVE_SAW, 20000, 1, 30, 500, 700, 250);
        if (mismatch_count == 0 && sample_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
